// File: rtl/multipoint_weight_calibration_macros.svh
// Assertion macros for the weight calibration block.
`ifndef MULTIPOINT_WEIGHT_CALIBRATION_MACROS_SVH
`define MULTIPOINT_WEIGHT_CALIBRATION_MACROS_SVH

// Same-cycle implication.
`define MWC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwc check failed");

// Next-cycle implication.
`define MWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwc check failed");

`endif

// File: rtl/mwc_pkg.sv
// Shared types, codes and constants of the weight calibration block.
`default_nettype none

package mwc_pkg;

    localparam int NUM_POINTS_DEF    = 5;
    localparam int FRACTION_BITS_DEF = 6;

    localparam int CNT_W   = 16;
    localparam int FRAC_W  = 6;
    localparam int STAT_W  = 3;
    localparam int QUO_W   = 32;

    localparam logic [CNT_W-1:0] MAX_VALID_RST = 16'hFEFF;
    localparam logic [CNT_W-1:0] GRAMS_FULL    = 16'hFFFF;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID    = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERWEIGHT = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADCAL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_RAW        = 3'd4;
    localparam logic [STAT_W-1:0] ST_LOADED     = 3'd5;

    localparam logic [1:0] REG_ZERO      = 2'd0;
    localparam logic [1:0] REG_MAX_VALID = 2'd1;
    localparam logic [1:0] REG_MULTI     = 2'd2;
    localparam logic [1:0] REG_RAW       = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] weight;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/mwc_table.sv
// Calibration point memory: one write port, one registered read port.
`default_nettype none

module mwc_table #(
    parameter int NUM_POINTS = 5,
    parameter int AW         = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire mwc_pkg::entry_t  wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output mwc_pkg::entry_t       rd_data
);
    import mwc_pkg::*;

    entry_t                mem [NUM_POINTS];
    logic [NUM_POINTS-1:0] valid_reg;
    entry_t                rd_q_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

// File: rtl/mwc_div.sv
// Restoring divider, 32 by 16 bits, one quotient bit per cycle.
`default_nettype none

module mwc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    import mwc_pkg::*;

    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] div_reg;
    logic [4:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[15:0] : trial[15:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/multipoint_weight_calibration.sv
// Load and out-of-range items skip the sweep and the divider and go straight to the result stage.
// A conversion sweeps the point memory once (re-base and nearest search),
// multiplies, then runs the 32-step divider; only one item is in flight at a time.
// A finished result waits in the output register while the next item is taken.
// Reset: config registers to defaults, point table reads as zero, no result pending.
`default_nettype none

module multipoint_weight_calibration #(
    parameter int NUM_POINTS    = mwc_pkg::NUM_POINTS_DEF,
    parameter int FRACTION_BITS = mwc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // measured_count[15:0], entry_index[18:16], entry_count[34:19], entry_weight[50:35]
    input  wire logic [55:0] s_tdata,
    // mode[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // weight_grams[15:0], weight_fraction[21:16]
    output logic [23:0]      m_tdata,
    // status[2:0]
    output logic [2:0]       m_tuser
);
    import mwc_pkg::*;

    localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int CW = $clog2(NUM_POINTS + 1);
    localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((32'd1 << FRACTION_BITS) - 32'd1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_DWAIT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        state_reg;
    logic [CNT_W-1:0]  zero_count_reg;
    logic [CNT_W-1:0]  max_valid_reg;
    logic              multi_point_reg;
    logic              raw_output_reg;
    logic [CNT_W-1:0]  prev_zero_reg;
    logic [CW-1:0]     rd_cnt_reg;
    logic              proc_valid_reg;
    logic [AW-1:0]     proc_idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  shift_reg;
    logic [CNT_W-1:0]  best_dist_reg;
    logic [CNT_W-1:0]  best_cnt_reg;
    logic [CNT_W-1:0]  best_wt_reg;
    logic              den_zero_reg;
    logic [CNT_W-1:0]  res_grams_reg;
    logic [FRAC_W-1:0] res_frac_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic              m_tvalid_reg;
    logic [CNT_W-1:0]  m_grams_reg;
    logic [FRAC_W-1:0] m_frac_reg;
    logic [STAT_W-1:0] m_status_reg;

    logic              accept;
    logic              in_mode;
    logic [CNT_W-1:0]  in_count;
    logic [2:0]        in_index;
    logic [CNT_W-1:0]  in_ecount;
    logic [CNT_W-1:0]  in_eweight;
    logic              in_over;
    logic              cfg_wr;
    logic              out_free;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    entry_t            rd_data;
    logic [CNT_W-1:0]  shifted;
    logic [CNT_W-1:0]  delta;
    logic              take_best;
    logic              last_entry;
    logic [CNT_W-1:0]  num;
    logic [CNT_W-1:0]  den;
    logic [QUO_W-1:0]  prod;
    logic [QUO_W-1:0]  scaled;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [CNT_W-1:0]  q_grams;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_mode    = s_tuser[0];
    assign in_count   = s_tdata[15:0];
    assign in_index   = s_tdata[18:16];
    assign in_ecount  = s_tdata[34:19];
    assign in_eweight = s_tdata[50:35];
    assign in_over    = (in_count > max_valid_reg);

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ZERO:      prdata = {16'b0, zero_count_reg};
            REG_MAX_VALID: prdata = {16'b0, max_valid_reg};
            REG_MULTI:     prdata = {31'b0, multi_point_reg};
            REG_RAW:       prdata = {31'b0, raw_output_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        shifted    = rd_data.count + shift_reg;
        delta      = (cnt_reg > shifted) ? (cnt_reg - shifted) : (shifted - cnt_reg);
        take_best  = (proc_idx_reg == '0) || (multi_point_reg && (delta < best_dist_reg));
        last_entry = proc_valid_reg && (proc_idx_reg == AW'(NUM_POINTS - 1));
        num        = (cnt_reg < zero_count_reg) ? '0 : (cnt_reg - zero_count_reg);
        den        = (best_cnt_reg < zero_count_reg) ? '0 : (best_cnt_reg - zero_count_reg);
        prod       = best_wt_reg * num;
        scaled     = prod << FRACTION_BITS;
        div_start  = (state_reg == S_CALC);
        q_grams    = div_quo[FRACTION_BITS +: CNT_W];
    end

    // table ports: sweep owns the memory, loads write only from idle
    always_comb
    begin
        if ((state_reg == S_SWEEP) && proc_valid_reg)
        begin
            wr_en          = 1'b1;
            wr_addr        = proc_idx_reg;
            wr_data.count  = shifted;
            wr_data.weight = rd_data.weight;
        end
        else
        begin
            wr_en          = accept && in_mode && (5'(in_index) < 5'(NUM_POINTS));
            wr_addr        = AW'(in_index);
            wr_data.count  = in_ecount;
            wr_data.weight = in_eweight;
        end
        if (state_reg == S_SWEEP)
        begin
            rd_en   = (rd_cnt_reg < CW'(NUM_POINTS));
            rd_addr = rd_cnt_reg[AW-1:0];
        end
        else
        begin
            rd_en   = accept && !in_mode && !in_over;
            rd_addr = '0;
        end
    end

    mwc_table #(
        .NUM_POINTS (NUM_POINTS),
        .AW         (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            zero_count_reg  <= '0;
            max_valid_reg   <= MAX_VALID_RST;
            multi_point_reg <= 1'b1;
            raw_output_reg  <= 1'b0;
            prev_zero_reg   <= '0;
            rd_cnt_reg      <= '0;
            proc_valid_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_ZERO:      zero_count_reg  <= pwdata[15:0];
                    REG_MAX_VALID: max_valid_reg   <= pwdata[15:0];
                    REG_MULTI:     multi_point_reg <= pwdata[0];
                    REG_RAW:       raw_output_reg  <= pwdata[0];
                    default:       ;
                endcase
            end

            if ((state_reg == S_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_mode || in_over)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg      <= S_SWEEP;
                            prev_zero_reg  <= zero_count_reg;
                            rd_cnt_reg     <= CW'(1);
                            proc_valid_reg <= 1'b1;
                        end
                    end
                end
                S_SWEEP:
                begin
                    if (rd_cnt_reg < CW'(NUM_POINTS))
                    begin
                        rd_cnt_reg     <= rd_cnt_reg + CW'(1);
                        proc_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        proc_valid_reg <= 1'b0;
                    end
                    if (last_entry)
                    begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_reg      <= in_count;
                    shift_reg    <= zero_count_reg - prev_zero_reg;
                    proc_idx_reg <= '0;
                    if (in_mode)
                    begin
                        res_grams_reg  <= '0;
                        res_frac_reg   <= '0;
                        res_status_reg <= ST_LOADED;
                    end
                    else
                    begin
                        res_grams_reg  <= in_count;
                        res_frac_reg   <= '0;
                        res_status_reg <= ST_INVALID;
                    end
                end
            end
            S_SWEEP:
            begin
                proc_idx_reg <= rd_cnt_reg[AW-1:0];
                if (proc_valid_reg && take_best)
                begin
                    best_dist_reg <= delta;
                    best_cnt_reg  <= shifted;
                    best_wt_reg   <= rd_data.weight;
                end
            end
            S_CALC:
            begin
                den_zero_reg <= (den == '0);
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    if (raw_output_reg)
                    begin
                        res_grams_reg  <= cnt_reg;
                        res_frac_reg   <= '0;
                        res_status_reg <= ST_RAW;
                    end
                    else if (den_zero_reg)
                    begin
                        res_grams_reg  <= '0;
                        res_frac_reg   <= '0;
                        res_status_reg <= ST_BADCAL;
                    end
                    else
                    begin
                        res_grams_reg  <= q_grams;
                        res_frac_reg   <= div_quo[FRAC_W-1:0] & FRAC_MASK;
                        res_status_reg <= (q_grams == GRAMS_FULL) ? ST_OVERWEIGHT : ST_OK;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_grams_reg  <= res_grams_reg;
                    m_frac_reg   <= res_frac_reg;
                    m_status_reg <= res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b0, m_frac_reg, m_grams_reg};
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

// File: rtl/mwc_checker.sv
// Port-level checks of the weight calibration block, bound to the top level.
`default_nettype none
`include "multipoint_weight_calibration_macros.svh"

module mwc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [2:0]  m_tuser
);
    import mwc_pkg::*;

    logic frac_zero_kind;
    logic grams_zero_kind;

    assign frac_zero_kind  = (m_tuser == ST_INVALID) || (m_tuser == ST_BADCAL)
                             || (m_tuser == ST_RAW) || (m_tuser == ST_LOADED);
    assign grams_zero_kind = (m_tuser == ST_BADCAL) || (m_tuser == ST_LOADED);

    `MWC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `MWC_ASSERT_IMPL(a_status_range, clk, rst_n, m_tvalid, m_tuser <= ST_LOADED)
    `MWC_ASSERT_IMPL(a_frac_zero, clk, rst_n, m_tvalid && frac_zero_kind, m_tdata[21:16] == 6'd0)
    `MWC_ASSERT_IMPL(a_grams_zero, clk, rst_n, m_tvalid && grams_zero_kind, m_tdata[15:0] == 16'd0)

endmodule

bind multipoint_weight_calibration mwc_checker u_mwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: verif/multipoint_weight_calibration_tb.sv
// Testbench for the multipoint weight calibration block: streams items, predicts and checks.
module multipoint_weight_calibration_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwc_pkg::*;

    localparam logic MODE_CONVERT = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;
    localparam int   DRAIN_CYCLES = 60;
    localparam int   CYCLE_LIMIT  = 500000;
    localparam int   PER_PHASE    = 85;

    typedef struct packed {
        logic        mode;
        logic [15:0] count;
        logic [2:0]  slot;
        logic [15:0] ref_count;
        logic [15:0] ref_weight;
    } scale_item_t;

    typedef struct packed {
        logic [15:0] grams;
        logic [5:0]  frac;
        logic [2:0]  status;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // measured_count[15:0], entry_index[18:16], entry_count[34:19], entry_weight[50:35]
    logic [55:0] s_tdata = '0;
    // mode[0]
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // weight_grams[15:0], weight_fraction[21:16]
    logic [23:0] m_tdata;
    // status[2:0]
    logic [2:0]  m_tuser;

    multipoint_weight_calibration u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // Predictor state
    logic [15:0] cfg_zero      = 16'd0;
    logic [15:0] cfg_max_valid = MAX_VALID_RST;
    logic        cfg_multi     = 1'b1;
    logic        cfg_raw       = 1'b0;
    logic [15:0] point_count  [NUM_POINTS_DEF] = '{default: '0};
    logic [15:0] point_weight [NUM_POINTS_DEF] = '{default: '0};
    logic [15:0] last_zero = 16'd0;

    scale_item_t cal_items[$];
    reading_t    due_readings[$];
    scale_item_t next_item;
    scale_item_t seen_item;
    reading_t    due;
    logic        item_taken = 1'b0;
    int          send_idle_pct = 30;
    int          recv_idle_pct = 48;
    int          n_sent = 0;
    int          n_done = 0;
    int          errors = 0;
    int          cycles = 0;

    function automatic reading_t predict_reading(input scale_item_t it);
        reading_t    r;
        logic [31:0] num;
        logic [31:0] scaled;
        logic [31:0] quo;
        logic [15:0] den;
        logic [15:0] shift;
        logic [15:0] delta;
        logic [15:0] best_dist;
        int          sel;
        r = '{grams: '0, frac: '0, status: ST_LOADED};
        if (it.mode == MODE_LOAD) begin
            if (it.slot < NUM_POINTS_DEF) begin
                point_count[it.slot]  = it.ref_count;
                point_weight[it.slot] = it.ref_weight;
            end
            return r;
        end
        if (it.count > cfg_max_valid) begin
            r.grams  = it.count;
            r.status = ST_INVALID;
            return r;
        end
        num = (it.count < cfg_zero) ? 32'd0 : {16'd0, it.count - cfg_zero};
        // zero moved: re-base the whole table
        shift = cfg_zero - last_zero;
        for (int k = 0; k < NUM_POINTS_DEF; k++)
            point_count[k] = point_count[k] + shift;
        last_zero = cfg_zero;
        sel = 0;
        if (cfg_multi) begin
            best_dist = 16'hffff;
            for (int k = 0; k < NUM_POINTS_DEF; k++)
            begin
                delta = (it.count > point_count[k]) ? it.count - point_count[k]
                                                    : point_count[k] - it.count;
                if (delta < best_dist)
                begin
                    best_dist = delta;
                    sel = k;
                end
            end
        end
        den = (point_count[sel] < cfg_zero) ? 16'd0 : point_count[sel] - cfg_zero;
        scaled = {16'd0, point_weight[sel]} * num;
        scaled = scaled << FRACTION_BITS_DEF;
        if (den != 16'd0) begin
            quo      = scaled / {16'd0, den};
            r.grams  = quo[FRACTION_BITS_DEF +: 16];
            r.frac   = quo[FRACTION_BITS_DEF-1:0];
            r.status = (r.grams == GRAMS_FULL) ? ST_OVERWEIGHT : ST_OK;
        end
        else
        begin
            r.status = ST_BADCAL;
        end
        if (cfg_raw) begin
            r.grams  = it.count;
            r.frac   = '0;
            r.status = ST_RAW;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic scale_item_t convert_item(input logic [15:0] c);
        scale_item_t it;
        it.mode       = MODE_CONVERT;
        it.count      = c;
        it.slot       = 3'($urandom);
        it.ref_count  = 16'($urandom);
        it.ref_weight = 16'($urandom);
        return it;
    endfunction

    function automatic scale_item_t load_item(input logic [2:0] slot, input logic [15:0] cnt,
                                              input logic [15:0] wt);
        scale_item_t it;
        it.mode       = MODE_LOAD;
        it.count      = 16'($urandom);
        it.slot       = slot;
        it.ref_count  = cnt;
        it.ref_weight = wt;
        return it;
    endfunction

    function automatic void queue_item(input scale_item_t it);
        cal_items.push_back(it);
        n_sent++;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ZERO:      cfg_zero = value;
            REG_MAX_VALID: cfg_max_valid = value;
            REG_MULTI:     cfg_multi = value[0];
            REG_RAW:       cfg_raw = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] zero_v, input logic [15:0] max_v,
                             input logic multi_v, input logic raw_v);
        write_reg(REG_ZERO, zero_v);
        write_reg(REG_MAX_VALID, max_v);
        write_reg(REG_MULTI, {15'd0, multi_v});
        write_reg(REG_RAW, {15'd0, raw_v});
    endtask

    task automatic settle();
        while (n_done != n_sent) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input int n);
        int span;
        int step;
        int r;
        span = 65535 - int'(cfg_zero);
        if (span < 1)
            span = 1;
        step = (span / NUM_POINTS_DEF > 1) ? span / NUM_POINTS_DEF : 1;
        // a valid conversion first, so the fresh table is not shifted later
        queue_item(convert_item(16'($urandom_range(0, cfg_max_valid))));
        for (int k = 0; k < NUM_POINTS_DEF; k++)
            queue_item(load_item(3'(k), 16'(int'(cfg_zero) + k * step + $urandom_range(1, step)),
                                 16'($urandom)));
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 10)
                queue_item(load_item(3'($urandom_range(7)), 16'($urandom), 16'($urandom)));
            else if (r < 20)
                queue_item(load_item(3'($urandom_range(NUM_POINTS_DEF - 1)),
                                     16'(int'(cfg_zero) + $urandom_range(1, span)),
                                     16'($urandom)));
            else if (r < 30)
                queue_item(convert_item(16'($urandom)));
            else if (r < 35)
                queue_item(convert_item(cfg_zero - 16'($urandom_range(1, 200))));
            else
                queue_item(convert_item(16'(int'(cfg_zero) + $urandom_range(0, span))));
        end
    endtask

    // Stream driver: inputs move on the falling edge
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!s_tvalid || item_taken) begin
                if (cal_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = cal_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, next_item.ref_weight, next_item.ref_count,
                                 next_item.slot, next_item.count};
                    s_tuser  <= next_item.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: both handshakes sampled on the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            item_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                n_done++;
                if (due_readings.size() == 0) begin
                    $error("unexpected result: grams %0h status %0d", m_tdata[15:0], m_tuser);
                    errors++;
                end
                else
                begin
                    due = due_readings.pop_front();
                    check_field("weight_grams", due.grams, m_tdata[15:0]);
                    check_field("weight_fraction", due.frac, m_tdata[21:16]);
                    check_field("status", due.status, m_tuser);
                end
            end
            if (s_tvalid && s_tready) begin
                seen_item.mode       = s_tuser[0];
                seen_item.count      = s_tdata[15:0];
                seen_item.slot       = s_tdata[18:16];
                seen_item.ref_count  = s_tdata[34:19];
                seen_item.ref_weight = s_tdata[50:35];
                due_readings.push_back(predict_reading(seen_item));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults after reset; empty table, then overweight and search cases
        queue_item(convert_item(16'd100));
        queue_item(load_item(3'd0, 16'd1, 16'hffff));
        queue_item(convert_item(16'd1));
        queue_item(load_item(3'd5, 16'd1234, 16'd77));
        queue_item(load_item(3'd7, 16'd4321, 16'd88));
        queue_item(load_item(3'd1, 16'd20000, 16'd5000));
        queue_item(load_item(3'd2, 16'd40000, 16'd10000));
        queue_item(load_item(3'd3, 16'd60000, 16'd15000));
        queue_item(load_item(3'd4, 16'hffff, 16'hffff));
        queue_item(convert_item(16'd0));
        queue_item(convert_item(16'd30000));
        queue_item(convert_item(16'd65000));
        queue_item(convert_item(16'hfeff));
        queue_item(convert_item(16'hff00));
        queue_item(convert_item(16'hffff));
        settle();

        // no point closer than full scale falls back to point 0
        configure(16'd0, 16'hffff, 1'b1, 1'b0);
        for (int k = 0; k < NUM_POINTS_DEF; k++)
            queue_item(load_item(3'(k), 16'd0, 16'd1));
        queue_item(convert_item(16'hffff));
        settle();

        // count and reference below zero
        configure(16'd30000, MAX_VALID_RST, 1'b1, 1'b0);
        queue_item(convert_item(16'd500));
        queue_item(load_item(3'd0, 16'd10000, 16'd100));
        queue_item(load_item(3'd1, 16'd40000, 16'd200));
        queue_item(convert_item(16'd10000));
        queue_item(convert_item(16'd45000));
        settle();

        configure(16'd30000, MAX_VALID_RST, 1'b0, 1'b1);
        queue_item(convert_item(16'd45000));
        queue_item(convert_item(16'hffff));
        settle();
        write_reg(REG_RAW, 16'd0);
        queue_item(convert_item(16'd45000));

        for (int p = 0; p < 8; p++)
        begin
            settle();
            case (p)
                0: configure(16'd0, 16'hffff, 1'b1, 1'b0);
                1: configure(16'($urandom_range(1, 4000)), MAX_VALID_RST, 1'b1, 1'b0);
                2: configure(16'($urandom), 16'($urandom), 1'b0, 1'b0);
                3: configure(16'hffff, 16'hffff, 1'b1, 1'b0);
                4: configure(16'($urandom_range(0, 2000)), 16'd0, 1'b1, 1'b0);
                5: configure(16'($urandom_range(0, 8000)), MAX_VALID_RST, 1'b1, 1'b1);
                6: configure(16'($urandom_range(0, 1000)), 16'hffff, 1'b1, 1'b0);
                default: configure(16'd0, MAX_VALID_RST, 1'b0, 1'b0);
            endcase
            if (p == 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 30;
            end
            if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase(PER_PHASE);
        end
        settle();

        if (due_readings.size() != 0) begin
            $error("results still due at end: %0d", due_readings.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
